// ===== design/mutex_lock_manager_core_assert.svh =====
// ----------------------------------------------------------------------------
// Mutex lock manager assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MUTEX_LOCK_MANAGER_CORE_ASSERT_SVH
`define MUTEX_LOCK_MANAGER_CORE_ASSERT_SVH

// same-cycle implication
`define MLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mlm_pkg.sv =====
// ----------------------------------------------------------------------------
// mlm_pkg
// Shared types, codes and helpers of the mutex lock manager.
// ----------------------------------------------------------------------------
package mlm_pkg;

   localparam int DEF_NUM_MUTEXES = 32;
   localparam int DEF_NUM_TASKS   = 64;

   localparam int OP_W      = 2;
   localparam int MUTEX_W   = 8;
   localparam int TASK_W    = 6;
   localparam int STATUS_W  = 3;
   localparam int CREATED_W = 5;
   localparam int COUNT_W   = 6;

   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_LOCK   = 2'd1;
   localparam logic [OP_W-1:0] OP_UNLOCK = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DEADLOCK      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_PERMITTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_MEMORY     = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

   // one lock table entry
   typedef struct packed {
      logic              locked;
      logic [TASK_W-1:0] holder;
      logic              queued;
      logic [TASK_W-1:0] head;
      logic [TASK_W-1:0] tail;
   } mutex_entry_type;

   function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = (value == COUNT_MAX) ? value : value + COUNT_W'(1);
      return result;
   endfunction

   function automatic logic [COUNT_W-1:0] count_dec(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = (value == '0) ? value : value - COUNT_W'(1);
      return result;
   endfunction

endpackage

// ===== design/mlm_mutex_mem.sv =====
// ----------------------------------------------------------------------------
// mlm_mutex_mem
// Lock table: one entry per mutex, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlm_mutex_mem
   import mlm_pkg::*;
#(
   parameter int NUM_MUTEXES = DEF_NUM_MUTEXES,
   localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1
) (
   input  logic            clock,
   input  logic            rd_en,
   input  logic [MW-1:0]   rd_addr,
   output mutex_entry_type rd_data,
   input  logic            wr_en,
   input  logic [MW-1:0]   wr_addr,
   input  mutex_entry_type wr_data
);

   mutex_entry_type mem_ff [NUM_MUTEXES];
   mutex_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mlm_task_mem.sv =====
// ----------------------------------------------------------------------------
// mlm_task_mem
// Per-task stores: wait-queue links and held-lock counters.
// ----------------------------------------------------------------------------
module mlm_task_mem
   import mlm_pkg::*;
#(
   parameter int NUM_TASKS = DEF_NUM_TASKS,
   localparam int TW = $clog2(NUM_TASKS)
) (
   input  logic               clock,
   input  logic               reset,
   // held counters, cleared at reset through valid bits
   input  logic               held_rd_en,
   input  logic [TW-1:0]      held_rd_addr,
   output logic [COUNT_W-1:0] held_rd_data,
   input  logic               held_wr_en,
   input  logic [TW-1:0]      held_wr_addr,
   input  logic [COUNT_W-1:0] held_wr_data,
   // queue links, no reset
   input  logic               link_rd_en,
   input  logic [TW-1:0]      link_rd_addr,
   output logic [TASK_W-1:0]  link_rd_data,
   input  logic               link_wr_en,
   input  logic [TW-1:0]      link_wr_addr,
   input  logic [TASK_W-1:0]  link_wr_data
);

   logic [COUNT_W-1:0] held_mem_ff [NUM_TASKS];
   logic [TASK_W-1:0]  link_mem_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0] held_valid_ff;
   logic [COUNT_W-1:0] held_raw_ff;
   logic               held_hit_ff;
   logic [TASK_W-1:0]  link_raw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= '0;
         held_hit_ff   <= 1'b0;
      end else begin
         if (held_wr_en) begin
            held_valid_ff[held_wr_addr] <= 1'b1;
         end
         if (held_rd_en) begin
            held_hit_ff <= held_valid_ff[held_rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (held_wr_en) begin
         held_mem_ff[held_wr_addr] <= held_wr_data;
      end
      if (held_rd_en) begin
         held_raw_ff <= held_mem_ff[held_rd_addr];
      end
      if (link_wr_en) begin
         link_mem_ff[link_wr_addr] <= link_wr_data;
      end
      if (link_rd_en) begin
         link_raw_ff <= link_mem_ff[link_rd_addr];
      end
   end

   // never-written counter reads as zero
   assign held_rd_data = held_hit_ff ? held_raw_ff : '0;
   assign link_rd_data = link_raw_ff;

endmodule

// ===== design/mutex_lock_manager_core.sv =====
// ----------------------------------------------------------------------------
// mutex_lock_manager_core
// Hardware lock table with per-mutex FIFO wait queues and held counters.
// ----------------------------------------------------------------------------
//
//  channel   ports   direction   moves
//  -------   -----   ---------   ----------------------------------------
//  req       req_*   in          operation, mutex index, task id
//  rsp       rsp_*   out         status, created index, scheduler flags
//
//  A request reads the lock table entry and held counter, then decides and
//  writes back; an unlock that hands the mutex to a waiter adds a step:
//  the read of the waiter's link and counter in the task store.
//  Reset is synchronous; the task counters clear at once through valid bits,
//  and each mutex entry is zeroed when create hands it out. A stalled rsp
//  holds the last cycle of a request until the slot frees; a new request is
//  taken while a finished response still waits.
//
module mutex_lock_manager_core
   import mlm_pkg::*;
#(
   parameter int NUM_MUTEXES = DEF_NUM_MUTEXES,
   parameter int NUM_TASKS   = DEF_NUM_TASKS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [MUTEX_W-1:0]   req_mutex_index,
   input  logic [TASK_W-1:0]    req_task_id,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [CREATED_W-1:0] rsp_created_index,
   output logic                 rsp_caller_blocked,
   output logic                 rsp_caller_boosted,
   output logic                 rsp_caller_restore_priority,
   output logic                 rsp_woken_valid,
   output logic [TASK_W-1:0]    rsp_woken_task
);

   localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
   localparam int TW = $clog2(NUM_TASKS);
   localparam int CW = $clog2(NUM_MUTEXES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;   // lock table entry and counter in hand
   localparam logic [1:0] S_WAKE = 2'd2;   // waiter link and counter in hand

   logic [1:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff;
   logic [MUTEX_W-1:0]  mutex_ff;
   logic [TASK_W-1:0]   task_ff;
   // mutexes are never destroyed, so the created set is always 0..count-1
   logic [CW-1:0]       created_count_ff, created_count_in;
   logic [COUNT_W-1:0]  held_new_ff, held_new_in;
   logic                fwd_ff, fwd_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CREATED_W-1:0] rsp_created_ff;
   logic                rsp_blocked_ff, rsp_boosted_ff, rsp_restore_ff;
   logic                rsp_woken_valid_ff;
   logic [TASK_W-1:0]   rsp_woken_task_ff;

   logic                rsp_load;
   logic [STATUS_W-1:0] res_status;
   logic [CREATED_W-1:0] res_created;
   logic                res_blocked, res_boosted, res_restore, res_woken_valid;
   logic [TASK_W-1:0]   res_woken_task;

   logic                accept, slot_free, bad_req, hand_over;
   logic [COUNT_W-1:0]  held_dec, held_wake;

   // memory ports
   logic                mutex_rd_en, mutex_wr_en;
   logic [MW-1:0]       mutex_rd_addr, mutex_wr_addr;
   mutex_entry_type     mutex_rd_data, mutex_wr_data;
   logic                held_rd_en, held_wr_en, link_rd_en, link_wr_en;
   logic [TW-1:0]       held_rd_addr, held_wr_addr, link_rd_addr, link_wr_addr;
   logic [COUNT_W-1:0]  held_rd_data, held_wr_data;
   logic [TASK_W-1:0]   link_rd_data, link_wr_data;

   mlm_mutex_mem #(
      .NUM_MUTEXES(NUM_MUTEXES)
   ) u_mutex_mem (
      .clock  (clock),
      .rd_en  (mutex_rd_en),
      .rd_addr(mutex_rd_addr),
      .rd_data(mutex_rd_data),
      .wr_en  (mutex_wr_en),
      .wr_addr(mutex_wr_addr),
      .wr_data(mutex_wr_data)
   );

   mlm_task_mem #(
      .NUM_TASKS(NUM_TASKS)
   ) u_task_mem (
      .clock       (clock),
      .reset       (reset),
      .held_rd_en  (held_rd_en),
      .held_rd_addr(held_rd_addr),
      .held_rd_data(held_rd_data),
      .held_wr_en  (held_wr_en),
      .held_wr_addr(held_wr_addr),
      .held_wr_data(held_wr_data),
      .link_rd_en  (link_rd_en),
      .link_rd_addr(link_rd_addr),
      .link_rd_data(link_rd_data),
      .link_wr_en  (link_wr_en),
      .link_wr_addr(link_wr_addr),
      .link_wr_data(link_wr_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // range and existence checks, bounds before any use of the index
   assign bad_req = (op_ff == OP_UNUSED) || (mutex_ff >= NUM_MUTEXES) ||
                    (task_ff >= NUM_TASKS) || (mutex_ff >= created_count_ff);

   // unlock by the holder with a non-empty queue: ownership moves to the head
   assign hand_over = (op_ff == OP_UNLOCK) && !bad_req && mutex_rd_data.locked &&
                      (mutex_rd_data.holder == task_ff) && mutex_rd_data.queued;

   assign held_dec  = count_dec(held_rd_data);
   // head may be the caller itself on a corrupted queue
   assign held_wake = count_inc(fwd_ff ? held_new_ff : held_rd_data);

   always_comb begin
      state_in         = state_ff;
      created_count_in = created_count_ff;
      held_new_in      = held_new_ff;
      fwd_in           = fwd_ff;

      mutex_rd_en   = 1'b0;
      mutex_rd_addr = MW'(req_mutex_index);
      mutex_wr_en   = 1'b0;
      mutex_wr_addr = MW'(mutex_ff);
      mutex_wr_data = mutex_rd_data;
      held_rd_en    = 1'b0;
      held_rd_addr  = TW'(req_task_id);
      held_wr_en    = 1'b0;
      held_wr_addr  = TW'(task_ff);
      held_wr_data  = held_dec;
      link_rd_en    = 1'b0;
      link_rd_addr  = TW'(mutex_rd_data.head);
      link_wr_en    = 1'b0;
      link_wr_addr  = TW'(mutex_rd_data.tail);
      link_wr_data  = task_ff;

      rsp_load        = 1'b0;
      res_status      = ST_OK;
      res_created     = '0;
      res_blocked     = 1'b0;
      res_boosted     = 1'b0;
      res_restore     = 1'b0;
      res_woken_valid = 1'b0;
      res_woken_task  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mutex_rd_en = 1'b1;
               held_rd_en  = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (hand_over) begin
               // drop caller's count now, fetch the head's link and count
               held_wr_en   = 1'b1;
               held_rd_en   = 1'b1;
               held_rd_addr = TW'(mutex_rd_data.head);
               link_rd_en   = 1'b1;
               held_new_in  = held_dec;
               fwd_in       = (mutex_rd_data.head == task_ff);
               state_in     = S_WAKE;
            end else if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (op_ff == OP_CREATE) begin
                  if (created_count_ff < NUM_MUTEXES) begin
                     mutex_wr_en      = 1'b1;
                     mutex_wr_addr    = MW'(created_count_ff);
                     mutex_wr_data    = '0;
                     created_count_in = created_count_ff + CW'(1);
                     res_created      = CREATED_W'(created_count_ff);
                  end else begin
                     res_status = ST_NO_MEMORY;
                  end
               end else if (bad_req) begin
                  res_status = ST_INVALID;
               end else if (op_ff == OP_LOCK) begin
                  if (mutex_rd_data.locked && (mutex_rd_data.holder == task_ff)) begin
                     res_status = ST_DEADLOCK;
                  end else if (mutex_rd_data.locked) begin
                     // append caller to the wait queue
                     mutex_wr_en = 1'b1;
                     if (mutex_rd_data.queued) begin
                        link_wr_en = 1'b1;
                     end else begin
                        mutex_wr_data.head   = task_ff;
                        mutex_wr_data.queued = 1'b1;
                     end
                     mutex_wr_data.tail = task_ff;
                     res_blocked        = 1'b1;
                  end else begin
                     mutex_wr_en          = 1'b1;
                     mutex_wr_data.locked = 1'b1;
                     mutex_wr_data.holder = task_ff;
                     held_wr_en           = 1'b1;
                     held_wr_data         = count_inc(held_rd_data);
                     res_boosted          = 1'b1;
                  end
               end else begin
                  if (!mutex_rd_data.locked || (mutex_rd_data.holder != task_ff)) begin
                     res_status = ST_NOT_PERMITTED;
                  end else begin
                     // holder unlocks, nobody waiting: mutex goes free
                     held_wr_en           = 1'b1;
                     res_restore          = (held_dec == '0);
                     mutex_wr_en          = 1'b1;
                     mutex_wr_data.locked = 1'b0;
                     mutex_wr_data.holder = '0;
                  end
               end
            end
         end
         S_WAKE: begin
            if (slot_free) begin
               rsp_load             = 1'b1;
               state_in             = S_IDLE;
               mutex_wr_en          = 1'b1;
               mutex_wr_data.holder = mutex_rd_data.head;
               if (mutex_rd_data.head == mutex_rd_data.tail) begin
                  mutex_wr_data.queued = 1'b0;
               end else begin
                  mutex_wr_data.head = link_rd_data;
               end
               held_wr_en      = 1'b1;
               held_wr_addr    = TW'(mutex_rd_data.head);
               held_wr_data    = held_wake;
               res_restore     = (held_new_ff == '0);
               res_woken_valid = 1'b1;
               res_woken_task  = mutex_rd_data.head;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         created_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         created_count_ff <= created_count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_new_ff <= held_new_in;
      fwd_ff      <= fwd_in;
      if (accept) begin
         op_ff    <= req_operation;
         mutex_ff <= req_mutex_index;
         task_ff  <= req_task_id;
      end
      if (rsp_load) begin
         rsp_status_ff      <= res_status;
         rsp_created_ff     <= res_created;
         rsp_blocked_ff     <= res_blocked;
         rsp_boosted_ff     <= res_boosted;
         rsp_restore_ff     <= res_restore;
         rsp_woken_valid_ff <= res_woken_valid;
         rsp_woken_task_ff  <= res_woken_task;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_status                  = rsp_status_ff;
   assign rsp_created_index           = rsp_created_ff;
   assign rsp_caller_blocked          = rsp_blocked_ff;
   assign rsp_caller_boosted          = rsp_boosted_ff;
   assign rsp_caller_restore_priority = rsp_restore_ff;
   assign rsp_woken_valid             = rsp_woken_valid_ff;
   assign rsp_woken_task              = rsp_woken_task_ff;

endmodule

// ===== design/mlm_checker.sv =====
// ----------------------------------------------------------------------------
// mlm_checker
// Port-level checks on the mutex lock manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "mutex_lock_manager_core_assert.svh"

module mlm_checker
   import mlm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic [CREATED_W-1:0] rsp_created_index,
   input logic                 rsp_caller_blocked,
   input logic                 rsp_caller_boosted,
   input logic                 rsp_caller_restore_priority,
   input logic                 rsp_woken_valid,
   input logic [TASK_W-1:0]    rsp_woken_task
);

   // stalled response holds
   `MLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_woken_task), "rsp changed while stalled")

   `MLM_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_NO_MEMORY, "status code out of range")

   // hand-over is a successful unlock only
   `MLM_ASSERT_NOW(a_woken_ok, clock, reset, rsp_valid && rsp_woken_valid, (rsp_status == ST_OK) && !rsp_caller_blocked && !rsp_caller_boosted, "woken task on a non-unlock result")

   // failures leave all other fields clear
   `MLM_ASSERT_NOW(a_fail_clean, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_created_index == '0) && !rsp_caller_blocked && !rsp_caller_boosted && !rsp_caller_restore_priority && !rsp_woken_valid, "flags set on failure")

   // no response appears in the cycle right after a request enters
   `MLM_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready && (!rsp_valid || rsp_ready), !rsp_valid, "response ahead of table access")

endmodule

bind mutex_lock_manager_core mlm_checker u_mlm_checker (
   .clock                      (clock),
   .reset                      (reset),
   .req_valid                  (req_valid),
   .req_ready                  (req_ready),
   .rsp_valid                  (rsp_valid),
   .rsp_ready                  (rsp_ready),
   .rsp_status                 (rsp_status),
   .rsp_created_index          (rsp_created_index),
   .rsp_caller_blocked         (rsp_caller_blocked),
   .rsp_caller_boosted         (rsp_caller_boosted),
   .rsp_caller_restore_priority(rsp_caller_restore_priority),
   .rsp_woken_valid            (rsp_woken_valid),
   .rsp_woken_task             (rsp_woken_task)
);

// ===== tb/mutex_lock_manager_core_tb.sv =====
// ----------------------------------------------------------------------------
// mutex_lock_manager_core_tb
// Self-checking bench for the lock table: drives create, lock and unlock
// requests over valid/ready, predicts every response from a shadow table and
// compares it field by field as responses are accepted.
// ----------------------------------------------------------------------------
module mutex_lock_manager_core_tb
   import mlm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MUTEXES       = DEF_NUM_MUTEXES;
   localparam int TASKS         = DEF_NUM_TASKS;
   localparam int RANDOM_COUNT  = 1100;
   localparam int HOLDOFF_AFTER = 300;   // requests sent before the long stall
   localparam int HOLDOFF_LEN   = 250;   // cycles of the long receiver stall
   localparam int DRAIN_AT      = 700;   // sender waits for an empty pipe here
   localparam int CYCLE_LIMIT   = 200000;

   // one response as the block reports it
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [CREATED_W-1:0] created_index;
      logic                 caller_blocked;
      logic                 caller_boosted;
      logic                 caller_restore_priority;
      logic                 woken_valid;
      logic [TASK_W-1:0]    woken_task;
   } lock_result_type;

   // -------------------------------------------------------------------------
   // Shadow lock table. Every accepted request updates it and queues the
   // response it must produce; responses are checked in order.
   // -------------------------------------------------------------------------
   class lock_table_scoreboard_type;
      bit                created [MUTEXES];
      bit                locked  [MUTEXES];
      bit [TASK_W-1:0]   holder  [MUTEXES];
      bit                queued  [MUTEXES];
      bit [TASK_W-1:0]   head    [MUTEXES];
      bit [TASK_W-1:0]   tail    [MUTEXES];
      bit [TASK_W-1:0]   link    [TASKS];
      bit                link_set[TASKS];
      bit [COUNT_W-1:0]  held    [TASKS];
      bit                waiting [TASKS];   // task sits in some wait queue
      lock_result_type   expected_q[$];
      int unsigned       errors, checked;
      int unsigned       n_blocked, n_handoff, n_deadlock, n_no_memory;
      int unsigned       n_invalid, n_not_permitted;

      function void bump_held(bit [TASK_W-1:0] t);
         if (held[t] != COUNT_MAX) held[t]++;
      endfunction

      // an unlock that would follow a queue link that was never written
      function bit reads_blank_link(logic [OP_W-1:0] op, logic [MUTEX_W-1:0] m,
                                    logic [TASK_W-1:0] t);
         if (op != OP_UNLOCK || m >= MUTEXES) return 1'b0;
         if (!created[m] || !locked[m] || holder[m] != t || !queued[m]) return 1'b0;
         return (head[m] != tail[m]) && !link_set[head[m]];
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [MUTEX_W-1:0] m,
                                 logic [TASK_W-1:0] t);
         lock_result_type r;
         bit found;
         bit [TASK_W-1:0] w;
         int mi;
         r = '0;
         found = 0;
         mi = int'(m);
         if (op == OP_CREATE) begin
            r.status = ST_NO_MEMORY;
            for (int i = 0; i < MUTEXES; i++) begin
               if (!found && !created[i]) begin
                  found = 1;
                  created[i] = 1;
                  r.status = ST_OK;
                  r.created_index = i[CREATED_W-1:0];
               end
            end
         end else if (op == OP_UNUSED || mi >= MUTEXES || int'(t) >= TASKS ||
                      !created[mi]) begin
            r.status = ST_INVALID;
         end else if (op == OP_LOCK) begin
            if (locked[mi] && holder[mi] == t) begin
               r.status = ST_DEADLOCK;
            end else if (locked[mi]) begin
               if (queued[mi]) begin
                  link[tail[mi]] = t;
                  link_set[tail[mi]] = 1;
               end else begin
                  head[mi] = t;
                  queued[mi] = 1;
               end
               tail[mi] = t;
               waiting[t] = 1;
               r.caller_blocked = 1;
            end else begin
               locked[mi] = 1;
               holder[mi] = t;
               bump_held(t);
               r.caller_boosted = 1;
            end
         end else begin
            if (!locked[mi] || holder[mi] != t) begin
               r.status = ST_NOT_PERMITTED;
            end else begin
               if (held[t] != 0) held[t]--;
               r.caller_restore_priority = (held[t] == 0);
               if (!queued[mi]) begin
                  locked[mi] = 0;
                  holder[mi] = '0;
               end else begin
                  w = head[mi];
                  holder[mi] = w;
                  if (w == tail[mi]) queued[mi] = 0;
                  else head[mi] = link[w];
                  bump_held(w);
                  waiting[w] = 0;
                  r.woken_valid = 1;
                  r.woken_task = w;
               end
            end
         end
         case (r.status)
            ST_INVALID:       n_invalid++;
            ST_DEADLOCK:      n_deadlock++;
            ST_NOT_PERMITTED: n_not_permitted++;
            ST_NO_MEMORY:     n_no_memory++;
            default: begin
               if (r.caller_blocked) n_blocked++;
               if (r.woken_valid) n_handoff++;
            end
         endcase
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(lock_result_type got);
         lock_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding (status %0d)", got.status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("status", 8'(want.status), 8'(got.status));
         compare_field("created_index", 8'(want.created_index), 8'(got.created_index));
         compare_field("caller_blocked", 8'(want.caller_blocked), 8'(got.caller_blocked));
         compare_field("caller_boosted", 8'(want.caller_boosted), 8'(got.caller_boosted));
         compare_field("caller_restore_priority", 8'(want.caller_restore_priority),
                       8'(got.caller_restore_priority));
         compare_field("woken_valid", 8'(want.woken_valid), 8'(got.woken_valid));
         compare_field("woken_task", 8'(want.woken_task), 8'(got.woken_task));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // -------------------------------------------------------------------------
   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation = OP_CREATE;
   logic [MUTEX_W-1:0]   req_mutex_index = '0;
   logic [TASK_W-1:0]    req_task_id = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [CREATED_W-1:0] rsp_created_index;
   logic                 rsp_caller_blocked;
   logic                 rsp_caller_boosted;
   logic                 rsp_caller_restore_priority;
   logic                 rsp_woken_valid;
   logic [TASK_W-1:0]    rsp_woken_task;

   lock_table_scoreboard_type book;
   int                   sent_count = 0;
   int                   cycle_count = 0;
   bit                   hold_off = 0;   // long receiver stall in progress

   mutex_lock_manager_core uut (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_operation               (req_operation),
      .req_mutex_index             (req_mutex_index),
      .req_task_id                 (req_task_id),
      .rsp_valid                   (rsp_valid),
      .rsp_ready                   (rsp_ready),
      .rsp_status                  (rsp_status),
      .rsp_created_index           (rsp_created_index),
      .rsp_caller_blocked          (rsp_caller_blocked),
      .rsp_caller_boosted          (rsp_caller_boosted),
      .rsp_caller_restore_priority (rsp_caller_restore_priority),
      .rsp_woken_valid             (rsp_woken_valid),
      .rsp_woken_task              (rsp_woken_task)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, book.pending());
         $display("FAIL mutex_lock_manager_core");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Called in the time step of a rising edge. Holds the request until the
   // edge where ready is seen high, then books it with the shadow table.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [MUTEX_W-1:0] m,
                               input logic [TASK_W-1:0] t);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_mutex_index <= m;
      req_task_id     <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_request(op, m, t);
      sent_count++;
   endtask

   // Mostly well-formed traffic: only runnable tasks issue requests, a task
   // that already holds a lock only goes for free mutexes or its own (so
   // nobody who holds a lock ever sleeps and every queue drains), and unlocks
   // come from the holder. The rest is noise over the whole field ranges,
   // including requests from tasks that are asleep in a queue.
   task automatic pick_request(output logic [OP_W-1:0] op, output logic [MUTEX_W-1:0] m,
                               output logic [TASK_W-1:0] t);
      int cand[$];
      int tries;
      bit wellformed;
      do begin
         cand.delete();
         op = OP_UNUSED;
         m = MUTEX_W'($urandom_range(255));
         t = TASK_W'($urandom_range(TASKS - 1));
         wellformed = ($urandom_range(99) < 85);
         tries = 0;
         while (wellformed && book.waiting[t] && tries < 32) begin
            t = TASK_W'($urandom_range(TASKS - 1));
            tries++;
         end
         if (wellformed && !book.waiting[t]) begin
            if ($urandom_range(99) < 5) begin
               op = OP_CREATE;
            end else begin
               if (book.held[t] != 0 && $urandom_range(99) < 55) begin
                  // release a held lock; now and then relock one (deadlock)
                  op = ($urandom_range(99) < 8) ? OP_LOCK : OP_UNLOCK;
                  for (int i = 0; i < MUTEXES; i++)
                     if (book.locked[i] && book.holder[i] == t) cand.push_back(i);
               end else begin
                  op = OP_LOCK;
                  for (int i = 0; i < MUTEXES; i++) begin
                     if (book.created[i] && (book.held[t] == 0 || !book.locked[i])) begin
                        cand.push_back(i);
                        // low indexes weighted up for contention
                        if (i < 8) begin
                           cand.push_back(i);
                           cand.push_back(i);
                        end
                     end
                  end
               end
               if (cand.size() == 0) op = OP_CREATE;
               else m = MUTEX_W'(cand[$urandom_range(cand.size() - 1)]);
            end
         end else begin
            op = OP_W'($urandom_range(3));
            if ($urandom_range(1)) m = MUTEX_W'($urandom_range(MUTEXES - 1));
         end
      end while (book.reads_blank_link(op, m, t));
   endtask

   initial begin : stimulus
      logic [OP_W-1:0]    op;
      logic [MUTEX_W-1:0] m;
      logic [TASK_W-1:0]  t;
      int burst_left;
      int gap;

      book = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: error codes, queueing and handoff order ----
      send_request(OP_UNUSED, 8'd255, 6'd63);  // unused operation
      send_request(OP_LOCK,   8'd0,   6'd0);   // mutex never created
      send_request(OP_UNLOCK, 8'd0,   6'd0);
      send_request(OP_CREATE, 8'd0,   6'd0);   // hands out 0
      send_request(OP_CREATE, 8'd255, 6'd63);  // hands out 1
      send_request(OP_LOCK,   8'd32,  6'd1);   // first index past the table
      send_request(OP_UNLOCK, 8'd255, 6'd1);
      send_request(OP_LOCK,   8'd0,   6'd0);   // free: boost
      send_request(OP_LOCK,   8'd0,   6'd0);   // own lock: deadlock
      send_request(OP_LOCK,   8'd0,   6'd5);   // queue 5, 63, 42
      send_request(OP_LOCK,   8'd0,   6'd63);
      send_request(OP_LOCK,   8'd0,   6'd42);
      send_request(OP_UNLOCK, 8'd0,   6'd5);   // held by someone else
      send_request(OP_UNLOCK, 8'd1,   6'd0);   // not locked at all
      send_request(OP_LOCK,   8'd1,   6'd0);   // task 0 now holds two
      send_request(OP_UNLOCK, 8'd0,   6'd0);   // still holds one: no restore
      send_request(OP_UNLOCK, 8'd0,   6'd5);   // handoffs in FIFO order
      send_request(OP_UNLOCK, 8'd0,   6'd63);
      send_request(OP_UNLOCK, 8'd0,   6'd42);  // queue empty: mutex freed
      send_request(OP_UNLOCK, 8'd1,   6'd0);
      send_request(OP_LOCK,   8'd1,   6'd21);
      send_request(OP_UNLOCK, 8'd1,   6'd21);
      send_request(OP_LOCK,   8'd0,   6'd63);  // freed mutex is taken again
      send_request(OP_UNUSED, 8'd0,   6'd0);

      // ---- random: bursts of back-to-back requests with idle gaps ----
      burst_left = 0;
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
            // keep offering while the receiver is held off so the block fills
            gap = hold_off ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (n == DRAIN_AT) begin
            // let every response come home before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (book.pending() != 0) @(posedge clock);
         end
         pick_request(op, m, t);
         send_request(op, m, t);
         burst_left--;
      end

      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);   // catch any stray late response

      $display("%0d requests, %0d responses checked: %0d queued, %0d handoffs",
               sent_count, book.checked, book.n_blocked, book.n_handoff);
      $display("errors seen: %0d invalid, %0d deadlock, %0d not permitted, %0d no memory",
               book.n_invalid, book.n_deadlock, book.n_not_permitted, book.n_no_memory);
      if (book.errors == 0)
         $display("PASS mutex_lock_manager_core");
      else
         $display("FAIL mutex_lock_manager_core");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: check on accept, then pick next cycle's ready. Ready
   // follows a rotating 16-bit mask that is redrawn at random; one long
   // hold-off stalls the block once enough requests have gone in.
   // -------------------------------------------------------------------------
   bit [15:0] ready_mask = '1;
   bit [3:0]  ready_phase = '0;
   int        mask_left = 0;
   int        holdoff_left = 0;
   bit        holdoff_done = 0;

   always @(posedge clock) begin : response_side
      lock_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status                  = rsp_status;
         got.created_index           = rsp_created_index;
         got.caller_blocked          = rsp_caller_blocked;
         got.caller_boosted          = rsp_caller_boosted;
         got.caller_restore_priority = rsp_caller_restore_priority;
         got.woken_valid             = rsp_woken_valid;
         got.woken_task              = rsp_woken_task;
         book.check_result(got);
      end

      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (!holdoff_done && sent_count >= HOLDOFF_AFTER) begin
         holdoff_done = 1;
         holdoff_left = HOLDOFF_LEN;
         hold_off = 1;
         rsp_ready <= 1'b0;
      end else begin
         hold_off = 0;
         if (mask_left == 0) begin
            mask_left = $urandom_range(16, 64);
            case ($urandom_range(3))
               0:       ready_mask = '1;                         // no stalls at all
               3:       ready_mask = 16'($urandom & $urandom);   // mostly stalled
               default: ready_mask = 16'($urandom);
            endcase
         end
         mask_left--;
         rsp_ready <= ready_mask[ready_phase];
         ready_phase = ready_phase + 4'd1;
      end
   end

endmodule
